// ----- hw/rtl/hps_pkg.sv -----
// hps_pkg: shared constants for the haptic pattern sequencer.
// Opcodes, alert levels, confirmation stages, register map and reset values.
// No dependencies.
`timescale 1ns / 1ps

package hps_pkg;

	// Field widths
	localparam int OpW    = 3;
	localparam int LevelW = 3;
	localparam int DutyW  = 8;
	localparam int MsW    = 16;
	localparam int CritW  = 15;
	localparam int StageW = 3;
	localparam int CfElW  = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;
	localparam int InDataW  = 8;
	localparam int OutDataW = 16;

	// Request opcodes
	localparam logic [OpW-1:0] OP_TICK  = 3'd0;
	localparam logic [OpW-1:0] OP_ALERT = 3'd1;
	localparam logic [OpW-1:0] OP_MODAL = 3'd2;
	localparam logic [OpW-1:0] OP_START = 3'd3;
	localparam logic [OpW-1:0] OP_STOP  = 3'd4;

	// Alert levels
	localparam logic [LevelW-1:0] LVL_NONE     = 3'd0;
	localparam logic [LevelW-1:0] LVL_GENTLE   = 3'd1;
	localparam logic [LevelW-1:0] LVL_MODERATE = 3'd2;
	localparam logic [LevelW-1:0] LVL_URGENT   = 3'd3;
	localparam logic [LevelW-1:0] LVL_CRITICAL = 3'd4;

	// Confirmation stages
	localparam logic [StageW-1:0] CF_IDLE  = 3'd0;
	localparam logic [StageW-1:0] CF_START = 3'd1;
	localparam logic [StageW-1:0] CF_STOP1 = 3'd2;
	localparam logic [StageW-1:0] CF_GAP   = 3'd3;
	localparam logic [StageW-1:0] CF_STOP2 = 3'd4;

	// Session confirmation timing
	localparam logic [DutyW-1:0] SESSION_DUTY   = 8'd180;
	localparam logic [CfElW-1:0] START_PULSE_MS = 8'd100;
	localparam logic [CfElW-1:0] STOP_PULSE_MS  = 8'd50;
	localparam logic [CfElW-1:0] STOP_GAP_MS    = 8'd80;

	// Register map
	localparam logic [CfgIdxW-1:0] REG_DUTY_LEVELS   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_GENTLE_PULSE  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MODERATE_ON   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MODERATE_GAP  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MODERATE_CYC  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_CRITICAL_ON   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_CRITICAL_OFF  = 3'd6;

	// Register reset values
	localparam logic [CfgDataW-1:0] RST_DUTY_LEVELS  = 32'hFF64_B478;
	localparam logic [MsW-1:0]      RST_GENTLE_PULSE = 16'd200;
	localparam logic [MsW-1:0]      RST_MODERATE_ON  = 16'd150;
	localparam logic [MsW-1:0]      RST_MODERATE_GAP = 16'd100;
	localparam logic [MsW-1:0]      RST_MODERATE_CYC = 16'd2000;
	localparam logic [CritW-1:0]    RST_CRITICAL_ON  = 15'd300;
	localparam logic [CritW-1:0]    RST_CRITICAL_OFF = 15'd200;

endpackage

// ----- hw/rtl/haptic_pattern_sequencer.sv -----
// haptic_pattern_sequencer: turns ticks and events into a motor PWM duty.
// Depends on hps_pkg for opcodes, levels, stages and the register map.
//
//   Channel | Direction | Contents
//   s_*     | in        | request: opcode, alert_level, led_only
//   m_*     | out       | result: motor_duty, motor_active
//   cfg_*   | in        | register write, index and data
//
// Each request is latched in an input stage, then processed combinationally
// into the result register; the sequencer state updates on that same edge.
// A request passes the input stage, then the result register; one request per
// cycle unless stalled. A stalled result holds its register; an empty input
// stage still fills. arst_n clears control state, loads register reset values.
`timescale 1ns / 1ps

module haptic_pattern_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side, tdata: opcode[2:0], alert_level[5:3], led_only[6]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hps_pkg::InDataW-1:0]   s_tdata,
	// master side, tdata: motor_duty[7:0], motor_active[8]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hps_pkg::OutDataW-1:0]  m_tdata,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [hps_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [hps_pkg::CfgDataW-1:0]  cfg_wdata
);
	import hps_pkg::*;

	// Configuration registers
	logic [CfgDataW-1:0] duty_levels_q;
	logic [MsW-1:0]      gentle_pulse_q;
	logic [MsW-1:0]      mod_on_q;
	logic [MsW-1:0]      mod_gap_q;
	logic [MsW-1:0]      mod_cyc_q;
	logic [CritW-1:0]    crit_on_q;
	logic [CritW-1:0]    crit_off_q;

	// Input stage
	logic              valid_s1;
	logic [OpW-1:0]    op_s1;
	logic [LevelW-1:0] lvl_s1;
	logic              led_s1;

	// Sequencer state
	logic [LevelW-1:0] level_q;
	logic              muted_q;
	logic [MsW-1:0]    phase_q;
	logic              gpend_q;
	logic              grun_q;
	logic [MsW-1:0]    gel_q;
	logic [StageW-1:0] stage_q;
	logic [CfElW-1:0]  cfel_q;
	logic [DutyW-1:0]  duty_q;

	// Output register
	logic              out_valid_q;
	logic [DutyW-1:0]  out_duty_q;

	// Next-state signals
	logic [LevelW-1:0] level_d;
	logic              muted_d;
	logic [MsW-1:0]    phase_d;
	logic              gpend_d;
	logic              grun_d;
	logic [MsW-1:0]    gel_d;
	logic [StageW-1:0] stage_d;
	logic [CfElW-1:0]  cfel_d;
	logic [DutyW-1:0]  duty_d;

	// Time-advance helpers
	logic [MsW-1:0]    cycle_len;
	logic [MsW:0]      phase_inc;
	logic [MsW-1:0]    phase_adv;
	logic [MsW-1:0]    gel_adv;
	logic [CfElW-1:0]  cfel_adv;
	logic [MsW:0]      mod_b;
	logic [MsW+1:0]    mod_c;
	logic              advance;

	// Handshake: stage 1 moves when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutDataW - DutyW - 1){1'b0}}, (out_duty_q != '0), out_duty_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_levels_q  <= RST_DUTY_LEVELS;
			gentle_pulse_q <= RST_GENTLE_PULSE;
			mod_on_q       <= RST_MODERATE_ON;
			mod_gap_q      <= RST_MODERATE_GAP;
			mod_cyc_q      <= RST_MODERATE_CYC;
			crit_on_q      <= RST_CRITICAL_ON;
			crit_off_q     <= RST_CRITICAL_OFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DUTY_LEVELS:  duty_levels_q  <= cfg_wdata;
				REG_GENTLE_PULSE: gentle_pulse_q <= cfg_wdata[MsW-1:0];
				REG_MODERATE_ON:  mod_on_q       <= cfg_wdata[MsW-1:0];
				REG_MODERATE_GAP: mod_gap_q      <= cfg_wdata[MsW-1:0];
				REG_MODERATE_CYC: mod_cyc_q      <= cfg_wdata[MsW-1:0];
				REG_CRITICAL_ON:  crit_on_q      <= cfg_wdata[CritW-1:0];
				REG_CRITICAL_OFF: crit_off_q     <= cfg_wdata[CritW-1:0];
				default: ;
			endcase
		end
	end

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tdata[2:0];
			lvl_s1 <= s_tdata[5:3];
			led_s1 <= s_tdata[6];
		end
	end

	// One millisecond of time passing
	always_comb begin
		unique case (level_q)
			LVL_MODERATE: cycle_len = mod_cyc_q;
			LVL_CRITICAL: cycle_len = {1'b0, crit_on_q} + {1'b0, crit_off_q};
			default:      cycle_len = '0;
		endcase
		phase_inc = {1'b0, phase_q} + 1'b1;
		phase_adv = (cycle_len == '0 || phase_inc >= {1'b0, cycle_len})
			? '0 : phase_inc[MsW-1:0];
		gel_adv   = (grun_q && gel_q != '1) ? gel_q + 1'b1 : gel_q;
		cfel_adv  = (stage_q != CF_IDLE && cfel_q != '1) ? cfel_q + 1'b1 : cfel_q;
		mod_b     = {1'b0, mod_on_q} + {1'b0, mod_gap_q};
		mod_c     = {1'b0, mod_b} + {2'b00, mod_on_q};
	end

	// Request processing
	always_comb begin
		level_d = level_q;
		muted_d = muted_q;
		phase_d = phase_q;
		gpend_d = gpend_q;
		grun_d  = grun_q;
		gel_d   = gel_q;
		stage_d = stage_q;
		cfel_d  = cfel_q;
		duty_d  = duty_q;
		unique case (op_s1)
			OP_TICK: begin
				phase_d = phase_adv;
				gel_d   = gel_adv;
				cfel_d  = cfel_adv;
				// session confirmation takes precedence
				unique case (stage_q)
					CF_START: begin
						if (cfel_adv >= START_PULSE_MS) begin
							duty_d  = '0;
							stage_d = CF_IDLE;
						end
					end
					CF_STOP1: begin
						if (cfel_adv >= STOP_PULSE_MS) begin
							duty_d  = '0;
							stage_d = CF_GAP;
							cfel_d  = '0;
						end
					end
					CF_GAP: begin
						if (cfel_adv >= STOP_GAP_MS) begin
							duty_d  = SESSION_DUTY;
							stage_d = CF_STOP2;
							cfel_d  = '0;
						end
					end
					CF_STOP2: begin
						if (cfel_adv >= STOP_PULSE_MS) begin
							duty_d  = '0;
							stage_d = CF_IDLE;
						end
					end
					default: begin
						stage_d = CF_IDLE;
						if (muted_q) begin
							duty_d = '0;
						end else begin
							// alert pattern on the advanced phase
							unique case (level_q)
								LVL_GENTLE: begin
									if (gpend_q && !grun_q) begin
										grun_d  = 1'b1;
										gpend_d = 1'b0;
										gel_d   = '0;
										duty_d  = duty_levels_q[7:0];
									end
									if (grun_d && gel_d >= gentle_pulse_q) begin
										duty_d = '0;
										grun_d = 1'b0;
									end
								end
								LVL_MODERATE: begin
									if ({2'b00, phase_adv} < {2'b00, mod_on_q})
										duty_d = duty_levels_q[15:8];
									else if ({1'b0, phase_adv} < mod_b)
										duty_d = '0;
									else if ({2'b00, phase_adv} < mod_c)
										duty_d = duty_levels_q[15:8];
									else
										duty_d = '0;
								end
								LVL_URGENT: begin
									if (duty_q == '0)
										duty_d = duty_levels_q[23:16];
								end
								LVL_CRITICAL: begin
									duty_d = (phase_adv < {1'b0, crit_on_q})
										? duty_levels_q[31:24] : '0;
								end
								default: duty_d = '0;
							endcase
						end
					end
				endcase
			end
			OP_ALERT: begin
				phase_d = '0;
				grun_d  = 1'b0;
				gpend_d = (lvl_s1 == LVL_GENTLE);
				duty_d  = '0;
				level_d = lvl_s1;
			end
			OP_MODAL: begin
				muted_d = led_s1;
				if (led_s1)
					duty_d = '0;
			end
			OP_START: begin
				stage_d = CF_START;
				cfel_d  = '0;
				duty_d  = SESSION_DUTY;
			end
			OP_STOP: begin
				stage_d = CF_STOP1;
				cfel_d  = '0;
				duty_d  = SESSION_DUTY;
			end
			default: ;
		endcase
	end

	// State and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LVL_NONE;
			muted_q     <= 1'b0;
			phase_q     <= '0;
			gpend_q     <= 1'b0;
			grun_q      <= 1'b0;
			gel_q       <= '0;
			stage_q     <= CF_IDLE;
			cfel_q      <= '0;
			duty_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				level_q <= level_d;
				muted_q <= muted_d;
				phase_q <= phase_d;
				gpend_q <= gpend_d;
				grun_q  <= grun_d;
				gel_q   <= gel_d;
				stage_q <= stage_d;
				cfel_q  <= cfel_d;
				duty_q  <= duty_d;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_duty_q <= duty_d;
	end

	// Checks
	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == CF_IDLE || stage_q == CF_START || stage_q == CF_STOP1 ||
		stage_q == CF_GAP || stage_q == CF_STOP2)
		else $error("confirmation stage out of range");

	a_gentle_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(gpend_q && grun_q))
		else $error("gentle pulse both pending and running");

	a_alert_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_ALERT) |=> phase_q == '0)
		else $error("phase not cleared by alert change");

	a_muted_off: assert property (@(posedge clk) disable iff (!arst_n)
		(muted_q && stage_q == CF_IDLE) |-> duty_q == '0)
		else $error("motor running while muted and idle");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(op_s1)))
		else $error("input stage lost a stalled request");

endmodule
